// File: src/dfd_pkg.sv
// dfd_pkg: types, constants and helper functions of the deauth flood detector
// used by dfd_cfg, dfd_core and deauth_flood_detector; depends on nothing
package dfd_pkg;

  localparam int NumChannelsDef = 14;
  localparam int MinFrameLenDef = 28;
  localparam int ChMax          = 14;

  localparam logic [7:0]  FcDeauth   = 8'hC0;
  localparam logic [7:0]  FcDisassoc = 8'hA0;
  localparam logic [15:0] CntMax     = 16'hFFFF;
  localparam logic [19:0] WinMax     = 20'hFFFFF;

  localparam logic [15:0] ThresholdRst = 16'd1;
  localparam logic [7:0]  WindowsRst   = 8'd1;
  localparam logic [15:0] DwellRst     = 16'd200;
  localparam logic [13:0] MaskRst      = 14'd1;
  localparam logic [3:0]  ChannelRst   = 4'd1;

  typedef enum logic [2:0] {
    CfgEnable    = 3'd0,
    CfgThreshold = 3'd1,
    CfgWindows   = 3'd2,
    CfgDwell     = 3'd3,
    CfgMask      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] threshold;
    logic [7:0]  windows;
    logic [15:0] dwell;
    logic [13:0] mask;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  first_byte;
    logic [15:0] length;
  } item_t;

  typedef struct packed {
    logic [3:0]  current_channel;
    logic [15:0] attacked_run;
    logic [15:0] packet_rate;
    logic        window_done;
    logic        under_attack;
    logic        attack_stopped;
    logic        attack_started;
  } res_t;

  // lowest set bit of a channel mask as {found, channel number}
  function automatic logic [4:0] lowest_ch(logic [13:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = ChMax - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = {1'b1, 4'(i + 1)};
      end
    end
    return r;
  endfunction

endpackage

// File: src/deauth_flood_detector.sv
// deauth_flood_detector: top level with input register, state core and result register
// depends on dfd_pkg, dfd_cfg and dfd_core
// an accepted item waits in the input register; its result is registered in the result register
// throughput: one item per cycle while results are taken; the state update is a single pass in dfd_core
// the input stalls only while both the input and the result register hold an item
// and the result is not taken; reset clears all counters, disables the detector and selects channel 1
module deauth_flood_detector #(
  parameter int NumChannels = dfd_pkg::NumChannelsDef,
  parameter int MinFrameLen = dfd_pkg::MinFrameLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // frame_first_byte[7:0], frame_length[23:8]
  input  logic        s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // attack_started[0], attack_stopped[1], under_attack[2], window_done[3],
  // packet_rate[19:4], attacked_run[35:20], current_channel[39:36]
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic           in_valid_q, in_valid_d;
  dfd_pkg::item_t in_item_q;
  logic           out_valid_q, out_valid_d;
  dfd_pkg::res_t  out_res_q;
  dfd_pkg::res_t  res;
  dfd_pkg::cfg_t  cfg;
  logic           arm;
  logic           step;
  logic           in_take;

  assign cfg_ready_o = 1'b1;

  dfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg),
    .arm_o   (arm)
  );

  // the held item moves on when the result register is free or being drained
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  dfd_core #(
    .NumChannels (NumChannels),
    .MinFrameLen (MinFrameLen)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .arm_i  (arm),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.mode       <= s_axis_tuser_i;
      in_item_q.first_byte <= s_axis_tdata_i[7:0];
      in_item_q.length     <= s_axis_tdata_i[23:8];
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.current_channel, out_res_q.attacked_run,
                            out_res_q.packet_rate, out_res_q.window_done,
                            out_res_q.under_attack, out_res_q.attack_stopped,
                            out_res_q.attack_started};

  // start and stop only happen when a window closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[3]) |-> (!m_axis_tdata_o[0] && !m_axis_tdata_o[1]))
    else $error("attack start or stop without a closed window");

  // a start always leaves the attack flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> m_axis_tdata_o[2])
    else $error("attack started but flag clear");

  // a held item is not dropped while the result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=> (in_valid_q && out_valid_q))
    else $error("item lost under output stall");

  // the monitored channel is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[39:36] != 4'd0))
    else $error("current channel is zero");

endmodule

// File: src/dfd_cfg.sv
// dfd_cfg: configuration registers of the deauth flood detector
// depends on dfd_pkg
module dfd_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [2:0]          index_i,
  input  logic [15:0]         data_i,
  output dfd_pkg::cfg_t       cfg_o,
  output logic                arm_o
);

  dfd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (dfd_pkg::cfg_idx_e'(index_i))
        dfd_pkg::CfgEnable:    cfg_d.enable    = data_i[0];
        dfd_pkg::CfgThreshold: cfg_d.threshold = data_i;
        dfd_pkg::CfgWindows:   cfg_d.windows   = data_i[7:0];
        dfd_pkg::CfgDwell:     cfg_d.dwell     = data_i;
        dfd_pkg::CfgMask:      cfg_d.mask      = data_i[13:0];
        default: ;
      endcase
    end
  end

  // enabling a stopped detector restarts all counting
  assign arm_o = we_i && (dfd_pkg::cfg_idx_e'(index_i) == dfd_pkg::CfgEnable)
                 && data_i[0] && !cfg_q.enable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.threshold <= dfd_pkg::ThresholdRst;
      cfg_q.windows   <= dfd_pkg::WindowsRst;
      cfg_q.dwell     <= dfd_pkg::DwellRst;
      cfg_q.mask      <= dfd_pkg::MaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/dfd_core.sv
// dfd_core: frame counting, window and run tracking and channel hopping state
// one item is applied per step; depends on dfd_pkg
module dfd_core #(
  parameter int NumChannels = dfd_pkg::NumChannelsDef,
  parameter int MinFrameLen = dfd_pkg::MinFrameLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfd_pkg::cfg_t       cfg_i,
  input  logic                arm_i,
  input  logic                step_i,
  input  dfd_pkg::item_t      item_i,
  output dfd_pkg::res_t       res_o
);

  localparam int ChLimit = (NumChannels < dfd_pkg::ChMax) ? NumChannels : dfd_pkg::ChMax;
  localparam logic [14:0] LimFull = (15'(1) << ChLimit) - 15'(1);
  localparam logic [13:0] LimMask = LimFull[13:0];

  logic [15:0] fc_q, fc_d;
  logic [15:0] rate_q, rate_d;
  logic [15:0] run_q, run_d;
  logic        flag_q, flag_d;
  logic [19:0] win_q, win_d;
  logic [15:0] hop_q, hop_d;
  logic [3:0]  ch_q, ch_d;

  logic [13:0] mask;
  logic [3:0]  n_ch;
  logic [19:0] interval;
  logic [19:0] win_inc;
  logic [15:0] hop_inc;
  logic [13:0] below;
  logic [4:0]  low_all, low_above, low_wrap;
  logic [3:0]  ch_next;
  logic        is_mgmt;
  logic        started, stopped, done;

  assign mask     = cfg_i.mask & LimMask;
  assign n_ch     = 4'($countones(mask));
  assign interval = {16'd0, n_ch} * {4'd0, cfg_i.dwell};
  assign win_inc  = (win_q == dfd_pkg::WinMax) ? win_q : win_q + 20'd1;
  assign hop_inc  = (hop_q == dfd_pkg::CntMax) ? hop_q : hop_q + 16'd1;

  // channels at or below the current one, for the cyclic search
  always_comb begin
    for (int i = 0; i < dfd_pkg::ChMax; i++) begin
      below[i] = (5'(i) < {1'b0, ch_q});
    end
  end

  assign low_all   = dfd_pkg::lowest_ch(mask);
  assign low_above = dfd_pkg::lowest_ch(mask & ~below);
  assign low_wrap  = dfd_pkg::lowest_ch(mask & below);
  assign ch_next   = low_above[4] ? low_above[3:0] :
                     (low_wrap[4] ? low_wrap[3:0] : ch_q);

  assign is_mgmt = (item_i.length >= 16'(MinFrameLen)) &&
                   ((item_i.first_byte == dfd_pkg::FcDeauth) ||
                    (item_i.first_byte == dfd_pkg::FcDisassoc));

  always_comb begin
    fc_d    = fc_q;
    rate_d  = rate_q;
    run_d   = run_q;
    flag_d  = flag_q;
    win_d   = win_q;
    hop_d   = hop_q;
    ch_d    = ch_q;
    started = 1'b0;
    stopped = 1'b0;
    done    = 1'b0;
    if (arm_i) begin
      fc_d   = '0;
      rate_d = '0;
      run_d  = '0;
      flag_d = 1'b0;
      win_d  = '0;
      hop_d  = '0;
      ch_d   = low_all[4] ? low_all[3:0] : ch_q;
    end else if (step_i && cfg_i.enable) begin
      if (!item_i.mode) begin
        if (is_mgmt && (fc_q != dfd_pkg::CntMax)) begin
          fc_d = fc_q + 16'd1;
        end
      end else begin
        win_d = win_inc;
        hop_d = hop_inc;
        if (win_inc >= interval) begin
          win_d  = '0;
          done   = 1'b1;
          rate_d = fc_q;
          fc_d   = '0;
          if (fc_q >= cfg_i.threshold) begin
            run_d = (run_q == dfd_pkg::CntMax) ? run_q : run_q + 16'd1;
          end else begin
            if (flag_q) begin
              stopped = 1'b1;
            end
            flag_d = 1'b0;
            run_d  = '0;
          end
          // start check sees the flag after a possible stop
          if ((run_d == {8'd0, cfg_i.windows}) && !flag_d) begin
            flag_d  = 1'b1;
            started = 1'b1;
          end
        end
        if ((n_ch > 4'd1) && (hop_inc >= cfg_i.dwell)) begin
          hop_d = '0;
          ch_d  = ch_next;
        end
      end
    end
  end

  always_comb begin
    res_o.attack_started  = started;
    res_o.attack_stopped  = stopped;
    res_o.under_attack    = flag_d;
    res_o.window_done     = done;
    res_o.packet_rate     = rate_d;
    res_o.attacked_run    = run_d;
    res_o.current_channel = ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= '0;
      rate_q <= '0;
      run_q  <= '0;
      flag_q <= 1'b0;
      win_q  <= '0;
      hop_q  <= '0;
      ch_q   <= dfd_pkg::ChannelRst;
    end else begin
      fc_q   <= fc_d;
      rate_q <= rate_d;
      run_q  <= run_d;
      flag_q <= flag_d;
      win_q  <= win_d;
      hop_q  <= hop_d;
      ch_q   <= ch_d;
    end
  end

endmodule
